### rtl/core/clock_offset_aligner_unit_assert.svh
// Assertion macros for the clock offset aligner.
`ifndef CLOCK_OFFSET_ALIGNER_UNIT_ASSERT_SVH
`define CLOCK_OFFSET_ALIGNER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define COA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define COA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/coa_pkg.sv
// Types, constants and scaling helpers shared by the clock offset aligner.
`default_nettype none

package coa_pkg;

  typedef enum logic [2:0] {
    ReqUtc         = 3'd0,
    ReqGpsRaw      = 3'd1,
    ReqSync        = 3'd2,
    ReqArrival     = 3'd3,
    ReqManual      = 3'd4,
    ReqUnlock      = 3'd5,
    ReqToSession   = 3'd6,
    ReqFromSession = 3'd7
  } coa_req_e;

  localparam logic [2:0] RankNone    = 3'd0;
  localparam logic [2:0] RankManual  = 3'd2;
  localparam logic [2:0] RankArrival = 3'd3;
  localparam logic [2:0] RankSync    = 3'd4;
  localparam logic [2:0] RankGpsRaw  = 3'd5;
  localparam logic [2:0] RankUtc     = 3'd6;

  localparam logic CfgGpsUnixOffset = 1'b0;
  localparam logic CfgLeapSeconds   = 1'b1;

  localparam logic [31:0] GpsUnixOffsetReset = 32'd315964800;
  localparam logic [7:0]  LeapSecondsReset   = 8'd18;

  localparam logic [30:0] NsPerS       = 31'd1000000000;
  localparam logic [63:0] MaxRoundTrip = 64'd60000000000;
  localparam logic [62:0] MinRttReset  = {63{1'b1}};

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] time_a;
    logic signed [63:0] time_b;
    logic signed [63:0] time_c;
  } coa_in_t;

  typedef struct packed {
    logic               changed;
    logic signed [63:0] converted_time;
    logic signed [63:0] current_offset;
    logic [2:0]         provenance_rank;
    logic               is_locked;
    logic [35:0]        last_round_trip;
    logic [62:0]        best_round_trip;
    logic [31:0]        sync_count;
    logic signed [63:0] first_source_time;
    logic signed [63:0] last_source_time;
  } coa_out_t;

  // Scaled event, ready for the state update.
  typedef struct packed {
    coa_req_e    req;
    logic        do_align;
    logic        do_sync;
    logic [2:0]  prov;
    logic [63:0] src;
    logic [63:0] abs_ns;
    logic [35:0] rtt;
    logic [63:0] val;
  } coa_mid_t;

  // x * 1000 = x * (1024 - 16 - 8), modulo 2^64.
  function automatic logic [63:0] mul_1000(input logic [63:0] x);
    mul_1000 = (x << 10) - (x << 4) - (x << 3);
  endfunction

  // x * 1e6 = x * (2^20 - 2^16 + 2^14 + 2^9 + 2^6), modulo 2^64.
  function automatic logic [63:0] mul_1e6(input logic [63:0] x);
    mul_1e6 = (x << 20) - (x << 16) + (x << 14) + (x << 9) + (x << 6);
  endfunction

endpackage

`default_nettype wire

### rtl/core/clock_offset_aligner_unit.sv
// Top level of the clock offset aligner: handshake, pipeline and alignment state.
`default_nettype none

// The block keeps one source clock's offset to a shared session timeline
// (session = source + offset) and answers every accepted transaction with one
// result carrying the whole alignment state after that event. It is a
// three-register pipeline: an input register, a scaling register that holds
// stamps already converted to nanoseconds (the constant multiplies and the
// sync-reply vetting sit in front of it), and a result register loaded by the
// state update. A new transaction can be taken every cycle until a result-side
// stall, backing up stage by stage, reaches the input; an accepted one passes
// the scaling and then the result register. The state is touched only when
// an event leaves the scaling register, so events take effect in strict
// arrival order. The two GPS configuration registers take effect for any
// event accepted after the write. Rank of an event: 6 UTC, 5 GPS raw, 4 sync,
// 3 arrival, 2 manual; a manual offset always wins and locks.
module clock_offset_aligner_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  coa_pkg::coa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output coa_pkg::coa_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);
  import coa_pkg::*;

  // Configuration
  logic [31:0] gps_off_q;
  logic [7:0]  leap_q;

  // Pipeline
  coa_in_t  in_q;
  logic     in_vld_q;
  coa_mid_t mid_d, mid_q;
  logic     mid_vld_q;
  coa_out_t res_d, res_q;
  logic     res_vld_q;
  logic     adv_res, adv_mid, upd;

  // Alignment state
  logic [63:0] epoch_d, epoch_q;
  logic        epoch_known_d, epoch_known_q;
  logic [63:0] offset_d, offset_q;
  logic [2:0]  rank_d, rank_q;
  logic        lock_d, lock_q;
  logic [63:0] first_d, first_q;
  logic        have_first_d, have_first_q;
  logic [63:0] last_d, last_q;
  logic [35:0] rtt_d, rtt_q;
  logic [62:0] min_rtt_d, min_rtt_q;
  logic [31:0] count_d, count_q;

  logic [63:0] epoch_used, new_off, conv;
  logic        take, chg;

  // Configuration writes: no wait, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gps_off_q <= GpsUnixOffsetReset;
      leap_q    <= LeapSecondsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGpsUnixOffset: gps_off_q <= cfg_wdata_i;
        CfgLeapSeconds:   leap_q    <= cfg_wdata_i[7:0];
        default:          ;
      endcase
    end
  end

  // Advance a stage when the one after it is empty or moving.
  assign adv_res    = !res_vld_q || out_ready_i;
  assign adv_mid    = !mid_vld_q || adv_res;
  assign in_ready_o = !in_vld_q || adv_mid;
  assign upd        = mid_vld_q && adv_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv_mid) begin
        mid_vld_q <= in_vld_q;
      end
      if (adv_res) begin
        res_vld_q <= mid_vld_q;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (in_vld_q && adv_mid) begin
      mid_q <= mid_d;
    end
    if (upd) begin
      res_q <= res_d;
    end
  end

  coa_prep u_prep (
    .in_i      (in_q),
    .gps_off_i (gps_off_q),
    .leap_i    (leap_q),
    .mid_o     (mid_d)
  );

  // State update for the event leaving the scaling register.
  assign epoch_used = epoch_known_q ? epoch_q : mid_q.abs_ns;
  assign new_off    = mid_q.abs_ns - epoch_used - mid_q.src;
  assign take       = !lock_q && (mid_q.prov >= rank_q);

  always_comb begin
    epoch_d       = epoch_q;
    epoch_known_d = epoch_known_q;
    offset_d      = offset_q;
    rank_d        = rank_q;
    lock_d        = lock_q;
    first_d       = first_q;
    have_first_d  = have_first_q;
    last_d        = last_q;
    rtt_d         = rtt_q;
    min_rtt_d     = min_rtt_q;
    count_d       = count_q;
    chg           = 1'b0;
    conv          = 64'd0;

    // Accepted sync reply: update round-trip statistics.
    if (mid_q.do_sync) begin
      rtt_d   = mid_q.rtt;
      count_d = count_q + 32'd1;
      if ({27'd0, mid_q.rtt} < min_rtt_q) begin
        min_rtt_d = {27'd0, mid_q.rtt};
      end
    end

    // Absolute time seen: note the source, adopt the epoch, maybe take offset.
    if (mid_q.do_align) begin
      if (!have_first_q) begin
        first_d      = mid_q.src;
        have_first_d = 1'b1;
      end
      last_d        = mid_q.src;
      epoch_d       = epoch_used;
      epoch_known_d = 1'b1;
      if (take) begin
        chg      = (new_off != offset_q) || (mid_q.prov != rank_q);
        offset_d = new_off;
        rank_d   = mid_q.prov;
      end
    end

    case (mid_q.req)
      ReqManual: begin
        chg      = (mid_q.val != offset_q) || (rank_q != RankManual);
        offset_d = mid_q.val;
        rank_d   = RankManual;
        lock_d   = 1'b1;
      end
      ReqUnlock: begin
        lock_d = 1'b0;
      end
      ReqToSession: begin
        conv = mid_q.val + offset_q;
      end
      ReqFromSession: begin
        conv = mid_q.val - offset_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d.changed           = chg;
    res_d.converted_time    = conv;
    res_d.current_offset    = offset_d;
    res_d.provenance_rank   = rank_d;
    res_d.is_locked         = lock_d;
    res_d.last_round_trip   = rtt_d;
    res_d.best_round_trip   = min_rtt_d;
    res_d.sync_count        = count_d;
    res_d.first_source_time = first_d;
    res_d.last_source_time  = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q       <= 64'd0;
      epoch_known_q <= 1'b0;
      offset_q      <= 64'd0;
      rank_q        <= RankNone;
      lock_q        <= 1'b0;
      first_q       <= 64'd0;
      have_first_q  <= 1'b0;
      last_q        <= 64'd0;
      rtt_q         <= 36'd0;
      min_rtt_q     <= MinRttReset;
      count_q       <= 32'd0;
    end else if (upd) begin
      epoch_q       <= epoch_d;
      epoch_known_q <= epoch_known_d;
      offset_q      <= offset_d;
      rank_q        <= rank_d;
      lock_q        <= lock_d;
      first_q       <= first_d;
      have_first_q  <= have_first_d;
      last_q        <= last_d;
      rtt_q         <= rtt_d;
      min_rtt_q     <= min_rtt_d;
      count_q       <= count_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  `include "clock_offset_aligner_unit_assert.svh"

  // A locked alignment can only carry the manual rank.
  `COA_ASSERT_NOW(a_lock_rank, clk_i, rst_ni, out_valid_o && out_data_o.is_locked, out_data_o.provenance_rank == RankManual, "locked result without manual rank")

  // The best round trip never exceeds the last one once a reply is counted.
  `COA_ASSERT_NOW(a_best_le_last, clk_i, rst_ni, out_valid_o && (out_data_o.sync_count != 32'd0), out_data_o.best_round_trip <= {27'd0, out_data_o.last_round_trip}, "best round trip above last")

  // The reply count moves only on an accepted sync reply.
  `COA_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, !(upd && mid_q.do_sync), $stable(count_q), "reply count moved without sync reply")

endmodule

`default_nettype wire

### rtl/core/coa_prep.sv
// Event scaling: converts one event's stamps to nanoseconds and vets sync replies.
`default_nettype none

module coa_prep (
  input  coa_pkg::coa_in_t  in_i,
  input  logic [31:0]       gps_off_i,
  input  logic [7:0]        leap_i,
  output coa_pkg::coa_mid_t mid_o
);
  import coa_pkg::*;

  logic [63:0]        a, b, c;
  logic [63:0]        rtt;
  logic               rtt_ok;
  logic signed [32:0] shift_s;
  logic signed [63:0] shift_ns;

  assign a = in_i.time_a;
  assign b = in_i.time_b;
  assign c = in_i.time_c;

  // GPS to unix shift in seconds, then in nanoseconds (fits 64 bits signed).
  assign shift_s  = $signed({1'b0, gps_off_i}) - $signed({25'd0, leap_i});
  assign shift_ns = shift_s * $signed({1'b0, NsPerS});

  // Round trip; the unsigned compare also rejects negative values.
  assign rtt    = c - a;
  assign rtt_ok = (a != 64'd0) && (b != 64'd0) && (rtt <= MaxRoundTrip);

  always_comb begin
    mid_o          = '0;
    mid_o.req      = coa_req_e'(in_i.req_type);
    mid_o.val      = a;
    mid_o.rtt      = rtt[35:0];
    case (coa_req_e'(in_i.req_type))
      ReqUtc: begin
        mid_o.do_align = (b != 64'd0);
        mid_o.prov     = RankUtc;
        mid_o.src      = mul_1e6(a);
        mid_o.abs_ns   = mul_1000(b);
      end
      ReqGpsRaw: begin
        mid_o.do_align = (b != 64'd0);
        mid_o.prov     = RankGpsRaw;
        mid_o.src      = mul_1000(a);
        mid_o.abs_ns   = mul_1000(b) + 64'(shift_ns);
      end
      ReqSync: begin
        mid_o.do_align = rtt_ok;
        mid_o.do_sync  = rtt_ok;
        mid_o.prov     = RankSync;
        mid_o.src      = b;
        mid_o.abs_ns   = a + {1'b0, rtt[63:1]};
      end
      ReqArrival: begin
        mid_o.do_align = 1'b1;
        mid_o.prov     = RankArrival;
        mid_o.src      = a;
        mid_o.abs_ns   = b;
      end
      default: begin
        mid_o.prov     = RankNone;
      end
    endcase
  end

endmodule

`default_nettype wire

### dv/clock_offset_aligner_unit_checker.sv
// Alignment predictor and result checker for the clock offset aligner testbench.
`default_nettype none

module clock_offset_aligner_unit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  coa_pkg::coa_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  coa_pkg::coa_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              end_of_test_i,
  output int unsigned       outstanding_o,
  output int unsigned       fail_count_o
);
  import coa_pkg::*;

  localparam int unsigned MaxReports = 100;
  localparam logic [63:0] NsPerMs    = 64'd1000000;
  localparam logic [63:0] NsPerUs    = 64'd1000;
  localparam logic [63:0] BestRttIdle = 64'h7FFF_FFFF_FFFF_FFFF;

  // Own copy of the alignment state and the GPS settings.
  logic [31:0] cfg_gps_offset_s;
  logic [7:0]  cfg_leap_s;
  logic [63:0] session_epoch;
  logic        epoch_valid;
  logic [63:0] src_offset;
  logic [2:0]  offset_rank;
  logic        manual_lock;
  logic [63:0] first_src;
  logic        first_src_valid;
  logic [63:0] latest_src;
  logic [63:0] last_rtt;
  logic [63:0] best_rtt;
  logic [31:0] accepted_syncs;

  coa_out_t    expected_states[$];
  coa_out_t    predicted;
  coa_out_t    wanted;
  int unsigned mismatch_count;
  bit          leftovers_reported;

  task automatic reset_alignment();
    cfg_gps_offset_s = GpsUnixOffsetReset;
    cfg_leap_s       = LeapSecondsReset;
    session_epoch    = '0;
    epoch_valid      = 1'b0;
    src_offset       = '0;
    offset_rank      = RankNone;
    manual_lock      = 1'b0;
    first_src        = '0;
    first_src_valid  = 1'b0;
    latest_src       = '0;
    last_rtt         = '0;
    best_rtt         = BestRttIdle;
    accepted_syncs   = '0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Note the source time, adopt the epoch, then take the offset if allowed.
  task automatic align_source(input logic [63:0] src, input logic [63:0] abs_ns,
                              input logic [2:0] prov, output logic taken);
    logic [63:0] off;
    if (!first_src_valid) begin
      first_src       = src;
      first_src_valid = 1'b1;
    end
    latest_src = src;
    if (!epoch_valid) begin
      session_epoch = abs_ns;
      epoch_valid   = 1'b1;
    end
    off   = (abs_ns - session_epoch) - src;
    taken = 1'b0;
    if (!manual_lock && prov >= offset_rank) begin
      taken       = (off != src_offset) || (prov != offset_rank);
      src_offset  = off;
      offset_rank = prov;
    end
  endtask

  task automatic predict_alignment(input coa_in_t ev, output coa_out_t res);
    logic [63:0] a, b, c, rtt, shift_s, conv;
    logic        chg;
    a    = ev.time_a;
    b    = ev.time_b;
    c    = ev.time_c;
    chg  = 1'b0;
    conv = '0;
    case (ev.req_type)
      ReqUtc: begin
        if (b != '0) align_source(a * NsPerMs, b * NsPerUs, RankUtc, chg);
      end
      ReqGpsRaw: begin
        if (b != '0) begin
          shift_s = {32'd0, cfg_gps_offset_s} - {56'd0, cfg_leap_s};
          align_source(a * NsPerUs, b * NsPerUs + shift_s * 64'(NsPerS), RankGpsRaw, chg);
        end
      end
      ReqSync: begin
        rtt = c - a;
        // Drop replies with a missing stamp or an implausible round trip.
        if (a != '0 && b != '0 && !rtt[63] && rtt <= MaxRoundTrip) begin
          last_rtt = rtt;
          if (rtt < best_rtt) best_rtt = rtt;
          accepted_syncs++;
          align_source(b, a + (rtt >> 1), RankSync, chg);
        end
      end
      ReqArrival: align_source(a, b, RankArrival, chg);
      ReqManual: begin
        chg         = (a != src_offset) || (offset_rank != RankManual);
        src_offset  = a;
        offset_rank = RankManual;
        manual_lock = 1'b1;
      end
      ReqUnlock: manual_lock = 1'b0;
      ReqToSession: conv = a + src_offset;
      default: conv = a - src_offset;
    endcase
    res.changed           = chg;
    res.converted_time    = conv;
    res.current_offset    = src_offset;
    res.provenance_rank   = offset_rank;
    res.is_locked         = manual_lock;
    res.last_round_trip   = last_rtt[35:0];
    res.best_round_trip   = best_rtt[62:0];
    res.sync_count        = accepted_syncs;
    res.first_source_time = first_src;
    res.last_source_time  = latest_src;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_alignment();
      expected_states.delete();
      mismatch_count     = 0;
      leftovers_reported = 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgGpsUnixOffset) cfg_gps_offset_s = cfg_wdata_i;
        else cfg_leap_s = cfg_wdata_i[7:0];
      end
      // Check the result first: it cannot belong to a transaction taken now.
      if (out_valid_i && out_ready_i) begin
        if (expected_states.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          wanted = expected_states.pop_front();
          check_field("changed", out_data_i.changed, wanted.changed);
          check_field("converted_time", out_data_i.converted_time, wanted.converted_time);
          check_field("current_offset", out_data_i.current_offset, wanted.current_offset);
          check_field("provenance_rank", out_data_i.provenance_rank,
                      wanted.provenance_rank);
          check_field("is_locked", out_data_i.is_locked, wanted.is_locked);
          check_field("last_round_trip", out_data_i.last_round_trip,
                      wanted.last_round_trip);
          check_field("best_round_trip", out_data_i.best_round_trip,
                      wanted.best_round_trip);
          check_field("sync_count", out_data_i.sync_count, wanted.sync_count);
          check_field("first_source_time", out_data_i.first_source_time,
                      wanted.first_source_time);
          check_field("last_source_time", out_data_i.last_source_time,
                      wanted.last_source_time);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_alignment(in_data_i, predicted);
        expected_states.push_back(predicted);
      end
      if (end_of_test_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (expected_states.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_states.size()));
        end
      end
    end
    outstanding_o <= expected_states.size();
    fail_count_o  <= mismatch_count;
  end

endmodule

`default_nettype wire

### dv/clock_offset_aligner_unit_tb.sv
// Top of the clock offset aligner testbench: clock, reset, stimulus and verdict.
`default_nettype none

module clock_offset_aligner_unit_tb;
  import coa_pkg::*;

  localparam int unsigned ItemsPerSegment = 213;
  localparam int unsigned Segments        = 6;
  localparam int unsigned HoldOffCycles   = 150;
  localparam int unsigned TailCycles      = 10;
  // About 1300 transactions; the limit sits well past a correct run even with
  // both sides stalling at random.
  localparam int unsigned CycleLimit      = 200000;
  localparam logic [63:0] MaxPos          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes         = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  coa_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  coa_out_t    out_data;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_wdata;
  logic        end_of_test;
  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned hold_requests;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycle_count;

  clock_offset_aligner_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  clock_offset_aligner_unit_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .end_of_test_i (end_of_test),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run: count cycles and give up well past any correct finish.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side. Stall at random per the current idle rate; when the stimulus
  // asks for a hold-off, drop ready for a long fixed stretch so that the
  // pipeline fills and the block has to stall its input.
  initial begin
    int unsigned served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic coa_in_t make_event(input coa_req_e req, input logic [63:0] a,
                                         input logic [63:0] b, input logic [63:0] c);
    coa_in_t ev;
    ev.req_type = req;
    ev.time_a   = a;
    ev.time_b   = b;
    ev.time_c   = c;
    return ev;
  endfunction

  // Mix full-width noise, the extremes, tiny values and plausible stamps.
  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(7))
      0, 1: return {$urandom(), $urandom()};
      2: begin
        case ($urandom_range(3))
          0: return MaxPos;
          1: return MinNeg;
          2: return AllOnes;
          default: return 64'd1;
        endcase
      end
      3: return 64'($urandom_range(1000));
      default: return {2'b00, 30'($urandom()), $urandom()};
    endcase
  endfunction

  // Mostly well-formed events with random content; sync replies are vetted
  // in the block, so most of them carry a plausible round trip.
  function automatic coa_in_t random_event();
    coa_in_t     ev;
    int unsigned pick;
    logic [63:0] rtt;
    pick = $urandom_range(99);
    ev   = make_event(ReqUtc, pick_stamp(), pick_stamp(), pick_stamp());
    if (pick < 12) begin
      ev.req_type = ReqUtc;
      if ($urandom_range(9) == 0) ev.time_b = '0;
    end else if (pick < 24) begin
      ev.req_type = ReqGpsRaw;
      if ($urandom_range(9) == 0) ev.time_b = '0;
    end else if (pick < 46) begin
      ev.req_type = ReqSync;
      if (ev.time_a == '0) ev.time_a = 64'd1;
      if (ev.time_b == '0) ev.time_b = 64'd1;
      case ($urandom_range(9))
        0: rtt = '0;
        1: rtt = MaxRoundTrip;
        2: rtt = MaxRoundTrip + 64'd1;
        3: rtt = AllOnes - 64'($urandom_range(1000));
        4: begin
          ev.time_a = '0;
          rtt       = 64'd1000;
        end
        5: begin
          ev.time_b = '0;
          rtt       = 64'd1000;
        end
        default: rtt = {28'd0, 4'($urandom_range(13)), $urandom()};
      endcase
      ev.time_c = ev.time_a + rtt;
    end else if (pick < 60) begin
      ev.req_type = ReqArrival;
    end else if (pick < 68) begin
      ev.req_type = ReqManual;
    end else if (pick < 80) begin
      ev.req_type = ReqUnlock;
    end else if (pick < 90) begin
      ev.req_type = ReqToSession;
    end else begin
      ev.req_type = ReqFromSession;
    end
    return ev;
  endfunction

  // Offer one transaction, idling first at the current rate, and hold it
  // until the block takes it.
  task automatic send_event(input coa_in_t ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CfgGpsUnixOffset;
    cfg_wdata     <= '0;
    end_of_test   <= 1'b0;
    hold_requests <= 0;
    tx_idle_pct   <= 15;
    rx_idle_pct   <= 51;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: conversions and bad events while
    // no source has been seen, then a climb through the ranks, the manual
    // lock and its release.
    send_event(make_event(ReqToSession, MaxPos, '0, '0));
    send_event(make_event(ReqFromSession, MinNeg, AllOnes, AllOnes));
    send_event(make_event(ReqUtc, 64'd123, '0, '0));
    send_event(make_event(ReqGpsRaw, 64'd5, '0, '0));
    send_event(make_event(ReqSync, '0, 64'd7, 64'd100));
    send_event(make_event(ReqSync, 64'd100, '0, 64'd200));
    send_event(make_event(ReqSync, 64'd1000, 64'd5, 64'd999));
    send_event(make_event(ReqSync, 64'd1000, 64'd5, 64'd1001 + MaxRoundTrip));
    send_event(make_event(ReqArrival, 64'd5000, 64'd1700000000000000000, '0));
    send_event(make_event(ReqSync, 64'd2000, 64'd3000, 64'd2000 + MaxRoundTrip));
    send_event(make_event(ReqSync, MaxPos - 64'd15, MinNeg, MaxPos - 64'd15));
    send_event(make_event(ReqGpsRaw, MaxPos, MinNeg, AllOnes));
    send_event(make_event(ReqUtc, MinNeg, MaxPos, '0));
    send_event(make_event(ReqArrival, 64'd1, 64'd2, '0));
    send_event(make_event(ReqManual, AllOnes, '0, '0));
    send_event(make_event(ReqManual, AllOnes, '0, '0));
    send_event(make_event(ReqUtc, 64'd10, 64'd20, '0));
    send_event(make_event(ReqUnlock, '0, '0, '0));
    send_event(make_event(ReqArrival, AllOnes, '0, '0));
    send_event(make_event(ReqToSession, '0, '0, '0));
    send_event(make_event(ReqFromSession, MaxPos, '0, '0));
    send_event(make_event(ReqManual, '0, '0, '0));
    send_event(make_event(ReqUnlock, '0, '0, '0));
    wait_drained();

    // Random part: two segments per idling pattern, each at its own GPS
    // settings, written only once the block has gone quiet.
    for (int seg = 0; seg < Segments; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct <= 15;
          rx_idle_pct <= 51;
        end
        1: begin
          tx_idle_pct <= 51;
          rx_idle_pct <= 15;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      case (seg)
        1: begin
          write_register(CfgGpsUnixOffset, 32'hFFFF_FFFF);
          write_register(CfgLeapSeconds, 32'd255);
        end
        2: begin
          // Leap seconds above the offset: the shift wraps below zero.
          write_register(CfgGpsUnixOffset, 32'd0);
          write_register(CfgLeapSeconds, 32'd255);
        end
        3: begin
          write_register(CfgGpsUnixOffset, GpsUnixOffsetReset);
          write_register(CfgLeapSeconds, 32'(LeapSecondsReset));
        end
        4: begin
          write_register(CfgGpsUnixOffset, 32'd0);
          write_register(CfgLeapSeconds, 32'd0);
        end
        default: begin
          write_register(CfgGpsUnixOffset, $urandom());
          write_register(CfgLeapSeconds, 32'($urandom_range(255)));
        end
      endcase
      for (int n = 0; n < ItemsPerSegment; n++) begin
        // Hold the result side off while the sender keeps offering.
        if (seg == 2 && n == 20) hold_requests <= hold_requests + 1;
        // Pause the sender mid-segment until everything has come back.
        if (seg == 4 && n == ItemsPerSegment / 2) wait_drained();
        send_event(random_event());
      end
      wait_drained();
    end

    // Let any stray late result show up, then ask for the leftover check.
    repeat (TailCycles) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
